// File: hdl/kpsd_pkg.sv
`default_nettype none
package kpsd_pkg;

    // Keypad geometry
    localparam int PIN_COUNT  = 5;
    localparam int SENSE_PINS = 5;
    localparam int KEY_COUNT  = 16;
    localparam int PIN_W      = 3;
    localparam int KEY_W      = 4;

    localparam logic [PIN_W:0] PIN_LIMIT = (PIN_W + 1)'(PIN_COUNT);

    // Encoder
    localparam logic [1:0] RESTING_POS = 2'd3;
    localparam logic [3:0] HIST_RESET  = 4'd3;

    // Configuration register indexes and reset values
    localparam logic CFG_REPEAT_DELAY = 1'b0;
    localparam logic CFG_REPEAT_SPEED = 1'b1;
    localparam logic [7:0] REPEAT_DELAY_RST = 8'd100;
    localparam logic [7:0] REPEAT_SPEED_RST = 8'd25;

    // Key event codes
    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_DOWN = 2'd1;
    localparam logic [1:0] EV_UP   = 2'd2;

    // Opcodes
    localparam logic OP_SCAN    = 1'b0;
    localparam logic OP_ENCODER = 1'b1;

    typedef struct packed {
        logic             opcode;
        logic [4:0]       pin_levels;
        logic [31:0]      now;
        logic [1:0]       encoder_pins;
    } t_in_item;

    typedef struct packed {
        logic [PIN_W-1:0] drive_row;
        logic [1:0]       key_event;
        logic [KEY_W-1:0] key_number;
        logic             repeat_valid;
        logic [KEY_W-1:0] repeat_key;
    } t_key_res;

    typedef struct packed {
        logic             knob_valid;
        logic [7:0]       knob_delta;
    } t_knob_res;

    // Quadrature transition table: step of fine position per history code
    function automatic logic [7:0] quad_step(input logic [3:0] hist);
        logic [7:0] step;
        unique case (hist)
            4'd1, 4'd7, 4'd8, 4'd14: step = 8'hff;
            4'd2, 4'd4, 4'd11, 4'd13: step = 8'h01;
            default:                  step = 8'h00;
        endcase
        return step;
    endfunction

endpackage
`default_nettype wire

// File: hdl/kpsd_in_if.sv
`default_nettype none
interface kpsd_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [4:0]  pin_levels;
    logic [31:0] now;
    logic [1:0]  encoder_pins;

    modport source (output valid, opcode, pin_levels, now, encoder_pins, input ready);
    modport sink   (input valid, opcode, pin_levels, now, encoder_pins, output ready);
endinterface
`default_nettype wire

// File: hdl/kpsd_out_if.sv
`default_nettype none
interface kpsd_out_if;
    logic              valid;
    logic              ready;
    logic [2:0]        drive_row;
    logic [1:0]        key_event;
    logic [3:0]        key_number;
    logic              repeat_valid;
    logic [3:0]        repeat_key;
    logic              knob_valid;
    logic signed [7:0] knob_delta;

    modport source (output valid, drive_row, key_event, key_number, repeat_valid,
                    repeat_key, knob_valid, knob_delta, input ready);
    modport sink   (input valid, drive_row, key_event, key_number, repeat_valid,
                    repeat_key, knob_valid, knob_delta, output ready);
endinterface
`default_nettype wire

// File: hdl/keypad_scan_debounce_repeat_knob_core.sv
// An accepted item passes the input register and then the result register; a stalled result
// can hold it in the input register between the two.
// Throughput: one item per cycle while results are taken; a stalled result holds the result
// register, the input register takes one more item and then the input stalls.
// Every item gives exactly one result.
// Reset (i_rst_n low, synchronous): scan restarts at row 0 / column 1, keys released,
// no repeat pending, encoder history at rest, detents cleared, repeat config to defaults.
`default_nettype none
module keypad_scan_debounce_repeat_knob_core
    import kpsd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [7:0] i_cfg_data,
    kpsd_in_if.sink         i_in,
    kpsd_out_if.source      o_out
);

    logic [7:0] r_repeat_delay;
    logic [7:0] r_repeat_speed;

    logic      r_s1_valid;
    t_in_item  r_s1_item;
    logic      r_out_valid;
    t_key_res  r_out_key;
    t_knob_res r_out_knob;

    logic      adv;
    logic      s1_scan;
    t_key_res  key_res;
    t_knob_res knob_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_delay <= REPEAT_DELAY_RST;
            r_repeat_speed <= REPEAT_SPEED_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_REPEAT_DELAY: r_repeat_delay <= i_cfg_data;
                CFG_REPEAT_SPEED: r_repeat_speed <= i_cfg_data;
                default:          r_repeat_delay <= r_repeat_delay;
            endcase
        end
    end

    assign adv        = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || adv;
    assign s1_scan    = (r_s1_item.opcode == OP_SCAN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_item.opcode       <= i_in.opcode;
            r_s1_item.pin_levels   <= i_in.pin_levels;
            r_s1_item.now          <= i_in.now;
            r_s1_item.encoder_pins <= i_in.encoder_pins;
        end
    end

    kpsd_scan u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv),
        .i_scan         (s1_scan),
        .i_pin_levels   (r_s1_item.pin_levels),
        .i_now          (r_s1_item.now),
        .i_repeat_delay (r_repeat_delay),
        .i_repeat_speed (r_repeat_speed),
        .o_res          (key_res)
    );

    kpsd_knob u_knob (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv),
        .i_scan         (s1_scan),
        .i_encoder_pins (r_s1_item.encoder_pins),
        .o_res          (knob_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_key  <= key_res;
            r_out_knob <= knob_res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.drive_row    = r_out_key.drive_row;
    assign o_out.key_event    = r_out_key.key_event;
    assign o_out.key_number   = r_out_key.key_number;
    assign o_out.repeat_valid = r_out_key.repeat_valid;
    assign o_out.repeat_key   = r_out_key.repeat_key;
    assign o_out.knob_valid   = r_out_knob.knob_valid;
    assign o_out.knob_delta   = signed'(r_out_knob.knob_delta);

endmodule
`default_nettype wire

// File: hdl/kpsd_scan.sv
`default_nettype none
module kpsd_scan
    import kpsd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_adv,
    input  wire logic        i_scan,
    input  wire logic [4:0]  i_pin_levels,
    input  wire logic [31:0] i_now,
    input  wire logic [7:0]  i_repeat_delay,
    input  wire logic [7:0]  i_repeat_speed,
    output t_key_res         o_res
);

    logic [PIN_W-1:0]     r_row, n_row;
    logic [PIN_W-1:0]     r_col, n_col;
    logic [KEY_W-1:0]     r_scan_key, n_scan_key;
    logic [KEY_COUNT-1:0] r_last, n_last;
    logic [KEY_COUNT-1:0] r_stable, n_stable;
    logic                 r_held_valid, n_held_valid;
    logic [KEY_W-1:0]     r_held_key, n_held_key;
    logic [31:0]          r_due, n_due;

    logic [7:0]       levels_ext;
    logic             paired;
    logic             pressed;
    logic             last_bit;
    logic             stable_bit;
    logic [1:0]       ev;
    logic [PIN_W-1:0] col_inc;
    logic [PIN_W-1:0] row_inc;
    logic             col_wrap;
    logic             row_wrap;
    logic [31:0]      due_diff;
    logic             fire;
    logic [31:0]      delay_ticks;
    logic [31:0]      speed_ticks;

    // Columns beyond the sensed pins read high (not pressed)
    assign levels_ext  = {{(8 - SENSE_PINS){1'b1}}, i_pin_levels};
    assign paired      = (r_col != r_row);
    assign pressed     = !levels_ext[r_col];
    assign last_bit    = r_last[r_scan_key];
    assign stable_bit  = r_stable[r_scan_key];
    assign delay_ticks = {22'd0, i_repeat_delay, 2'b00};
    assign speed_ticks = {22'd0, i_repeat_speed, 2'b00};
    assign col_inc     = r_col + PIN_W'(1);
    assign row_inc     = r_row + PIN_W'(1);
    assign col_wrap    = {1'b0, col_inc} >= PIN_LIMIT;
    assign row_wrap    = {1'b0, row_inc} >= PIN_LIMIT;

    always_comb begin
        n_last       = r_last;
        n_stable     = r_stable;
        n_held_valid = r_held_valid;
        n_held_key   = r_held_key;
        n_scan_key   = r_scan_key;
        ev           = EV_NONE;
        if (paired) begin
            if (pressed) begin
                if (last_bit && !stable_bit) begin
                    n_stable[r_scan_key] = 1'b1;
                    n_held_valid         = 1'b1;
                    n_held_key           = r_scan_key;
                    ev                   = EV_DOWN;
                end
                n_last[r_scan_key] = 1'b1;
            end else begin
                if (!last_bit && stable_bit) begin
                    n_stable[r_scan_key] = 1'b0;
                    if (r_held_valid && r_held_key == r_scan_key) begin
                        n_held_valid = 1'b0;
                    end
                    ev = EV_UP;
                end
                n_last[r_scan_key] = 1'b0;
            end
            n_scan_key = r_scan_key + KEY_W'(1);
        end
        n_col = col_inc;
        n_row = r_row;
        if (col_wrap) begin
            n_col = PIN_W'(1);
            n_row = row_inc;
            if (row_wrap) begin
                n_row      = '0;
                n_scan_key = '0;
            end
        end
    end

    // A fresh key-down sets due to now + delay, so the difference is the delay itself
    assign due_diff = (ev == EV_DOWN) ? delay_ticks : (r_due - i_now);
    assign fire     = n_held_valid && ((due_diff == 32'd0) || due_diff[31]);

    always_comb begin
        priority if (fire) begin
            n_due = i_now + speed_ticks;
        end else if (ev == EV_DOWN) begin
            n_due = i_now + delay_ticks;
        end else begin
            n_due = r_due;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row        <= '0;
            r_col        <= PIN_W'(1);
            r_scan_key   <= '0;
            r_last       <= '0;
            r_stable     <= '0;
            r_held_valid <= 1'b0;
            r_held_key   <= '0;
            r_due        <= '0;
        end else if (i_adv && i_scan) begin
            r_row        <= n_row;
            r_col        <= n_col;
            r_scan_key   <= n_scan_key;
            r_last       <= n_last;
            r_stable     <= n_stable;
            r_held_valid <= n_held_valid;
            r_held_key   <= n_held_key;
            r_due        <= n_due;
        end
    end

    always_comb begin
        o_res.drive_row    = i_scan ? n_row : r_row;
        o_res.key_event    = i_scan ? ev : EV_NONE;
        o_res.key_number   = (i_scan && ev != EV_NONE) ? r_scan_key : '0;
        o_res.repeat_valid = i_scan && fire;
        o_res.repeat_key   = (i_scan && fire) ? n_held_key : '0;
    end

endmodule
`default_nettype wire

// File: hdl/kpsd_knob.sv
`default_nettype none
module kpsd_knob
    import kpsd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_adv,
    input  wire logic       i_scan,
    input  wire logic [1:0] i_encoder_pins,
    output t_knob_res       o_res
);

    logic [3:0] r_hist, n_hist;
    logic [7:0] r_fine, n_fine;
    logic [7:0] r_det, n_det;

    logic [7:0]        fine_step;
    logic signed [7:0] pos;
    logic signed [7:0] det;

    assign n_hist    = {r_hist[1:0], i_encoder_pins};
    assign fine_step = r_fine + quad_step(n_hist);
    assign pos       = signed'(fine_step);
    assign det       = signed'(r_det);

    // Whole detents only counted when the knob rests
    always_comb begin
        n_fine = fine_step;
        n_det  = r_det;
        if (i_encoder_pins == RESTING_POS) begin
            if (pos > 8'sd1) begin
                if (det < 8'sd127) begin
                    n_det = r_det + 8'd1;
                end
                n_fine = '0;
            end else if (pos < -8'sd1) begin
                if (det > -8'sd127) begin
                    n_det = r_det - 8'd1;
                end
                n_fine = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= HIST_RESET;
            r_fine <= '0;
            r_det  <= '0;
        end else if (i_adv) begin
            if (i_scan) begin
                r_det <= '0;
            end else begin
                r_hist <= n_hist;
                r_fine <= n_fine;
                r_det  <= n_det;
            end
        end
    end

    assign o_res.knob_valid = i_scan && (r_det != 8'd0);
    assign o_res.knob_delta = o_res.knob_valid ? r_det : 8'd0;

endmodule
`default_nettype wire

// File: hdl/kpsd_chk.sv
`default_nettype none
module kpsd_chk
    import kpsd_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic [2:0]        i_drive_row,
    input wire logic [1:0]        i_key_event,
    input wire logic [3:0]        i_key_number,
    input wire logic              i_repeat_valid,
    input wire logic [3:0]        i_repeat_key,
    input wire logic              i_knob_valid,
    input wire logic signed [7:0] i_knob_delta
);

    // A stalled result keeps its row and key event
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_drive_row) && $stable(i_key_event)
            && $stable(i_key_number))
        else $error("result changed while stalled");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ({1'b0, i_drive_row} < PIN_LIMIT))
        else $error("drive_row beyond pin count");

    a_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_key_event == EV_NONE) |-> (i_key_number == 4'd0))
        else $error("key_number set without key event");

    a_repeat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_repeat_valid |-> (i_repeat_key == 4'd0))
        else $error("repeat_key set without repeat");

    // Reported detents are nonzero and saturated
    a_knob_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_knob_valid
            ? (i_knob_delta != 8'sd0 && i_knob_delta != -8'sd128)
            : (i_knob_delta == 8'sd0)))
        else $error("knob_delta out of range");

endmodule

bind keypad_scan_debounce_repeat_knob_core kpsd_chk u_kpsd_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_drive_row    (o_out.drive_row),
    .i_key_event    (o_out.key_event),
    .i_key_number   (o_out.key_number),
    .i_repeat_valid (o_out.repeat_valid),
    .i_repeat_key   (o_out.repeat_key),
    .i_knob_valid   (o_out.knob_valid),
    .i_knob_delta   (o_out.knob_delta)
);
`default_nettype wire
